[rtl/bpa_pkg.sv]
// Shared types, widths and codes for the bitmap page allocator.
package bpa_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int WORD_W     = 64;
  localparam int ADDR_W     = $clog2(MAX_BLOCKS);
  localparam int WCNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int PIDX_W     = ADDR_W + BIT_W;
  localparam int LIMIT_W    = WCNT_W + BIT_W;
  localparam int RUN_W      = BIT_W + 1;

  localparam int TYPE_W     = 3;
  localparam int PADDR_W    = 64;
  localparam int PCNT_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int FREE_W     = 17;
  localparam int SHIFT_W    = 5;
  localparam int BASE_W     = 52;
  localparam int TOTAL_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 52;

  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;
  localparam logic [BASE_W-1:0]  BASE_RST  = '0;
  localparam logic [TOTAL_W-1:0] TOTAL_RST = 17'd65536;
  localparam logic [FREE_W-1:0]  FREE_MAX  = '1;

  localparam logic [TYPE_W-1:0] REQ_ALLOC   = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_CONTIG  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_FREE    = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_RESERVE = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_CLEAR   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK,
    STS_NOMEM,
    STS_ALLOC_FAIL,
    STS_DOUBLE_FREE,
    STS_RANGE,
    STS_BAD_COUNT,
    STS_RESERVED
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_LOCATE,
    S_READ,
    S_MODIFY,
    S_SCAN,
    S_PADDR,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              found;
    logic [BIT_W-1:0]  off;
  } fit_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] word;
    logic [BIT_W-1:0]  bit_idx;
  } loc_t;

endpackage

[rtl/bpa_if.sv]
// Request and response channel interfaces.
interface bpa_req_if import bpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TYPE_W-1:0]   req_type;
  logic [PADDR_W-1:0]  address;
  logic [PCNT_W-1:0]   page_count;

  modport source (output valid, req_type, address, page_count, input ready);
  modport sink   (input valid, req_type, address, page_count, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PADDR_W-1:0]  page_address;
  logic [FREE_W-1:0]   free_count;

  modport source (output valid, status, page_address, free_count, input ready);
  modport sink   (input valid, status, page_address, free_count, output ready);
endinterface

[rtl/bpa_ram.sv]
// Simple dual-port synchronous RAM with registered read.
module bpa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/bpa_fit.sv]
// Finds the lowest offset in a map word where a run of free pages fits.
module bpa_fit import bpa_pkg::*; (
  input  logic [WORD_W-1:0] word,
  input  logic [RUN_W-1:0]  run_cnt,
  input  logic [WORD_W-1:0] run_mask,
  output fit_t              fit
);

  always_comb begin
    fit = '0;
    // scan high to low so the lowest fitting offset wins
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if ((i <= WORD_W - int'(run_cnt)) && (((word >> i) & run_mask) == '0)) begin
        fit.found = 1'b1;
        fit.off   = BIT_W'(i);
      end
    end
  end

endmodule

[rtl/bpa_xlat.sv]
// Byte address to map word and bit, with region bounds check.
module bpa_xlat import bpa_pkg::*; (
  input  logic [PADDR_W-1:0] address,
  input  logic [PADDR_W-1:0] base_addr,
  input  logic [SHIFT_W-1:0] page_shift,
  input  logic [WCNT_W-1:0]  num_words,
  output loc_t               loc
);

  logic [PADDR_W-1:0] diff;
  logic [PADDR_W-1:0] idx;
  logic [LIMIT_W-1:0] limit;

  always_comb begin
    diff  = address - base_addr;
    idx   = diff >> page_shift;
    limit = {num_words, {BIT_W{1'b0}}};
    loc.ok      = (address >= base_addr) && (idx[PADDR_W-1:PIDX_W] == '0) &&
                  (LIMIT_W'(idx[PIDX_W-1:0]) < limit);
    loc.word    = idx[PIDX_W-1:BIT_W];
    loc.bit_idx = idx[BIT_W-1:0];
  end

endmodule

[rtl/bitmap_page_allocator.sv]
// Bitmap page allocator top level: control, counters and page map RAM.
//
//  channel   dir  beat payload                              handshake
//  in_ch     in   req_type, address, page_count             valid/ready
//  out_ch    out  status, page_address, free_count          valid/ready
//  cfg_*     in   cfg_index, cfg_wdata                      cfg_we, no wait
//
// One request at a time. Free/reserve step through decode, locate, RAM read
// and write back. Allocations scan the map one word per cycle through the RAM
// read port. Clear sweeps every map word, one per cycle.
// After reset the same sweep runs with in_ch.ready low.
// A result waiting on out_ch does not block accepting the next request.
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bpa_req_if.sink               in_ch,
  bpa_rsp_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [ADDR_W-1:0] LAST_W = ADDR_W'(MAX_BLOCKS - 1);

  // configuration
  logic [SHIFT_W-1:0] page_shift_r;
  logic [BASE_W-1:0]  base_frame_r;
  logic [TOTAL_W-1:0] total_pages_r;
  logic [PADDR_W-1:0] base_addr_r;

  state_t state_r, state_nxt;

  logic [TYPE_W-1:0]  req_type_r;
  logic [PADDR_W-1:0] address_r;
  logic [PCNT_W-1:0]  page_count_r;

  logic [RUN_W-1:0]   run_cnt_r, run_cnt_nxt;
  logic [WORD_W-1:0]  run_mask_r, run_mask_nxt;
  logic [WCNT_W-1:0]  iss_w_r, iss_w_nxt;
  logic [WCNT_W-1:0]  chk_w_r, chk_w_nxt;
  logic               chk_v_r, chk_v_nxt;
  logic [ADDR_W-1:0]  clr_w_r, clr_w_nxt;
  loc_t               loc_r, loc_nxt;
  logic [PIDX_W-1:0]  pidx_r, pidx_nxt;
  logic [FREE_W-1:0]  free_r, free_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [PADDR_W-1:0] res_addr_r, res_addr_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [PADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [FREE_W-1:0]   out_free_r, out_free_nxt;

  // RAM port
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  logic [TOTAL_W-BIT_W-1:0] tot_words;
  logic [WCNT_W-1:0]        num_words;
  loc_t                     xlat_loc;
  fit_t                     fit;
  logic                     count_bad;
  logic                     scan_done;
  logic [BASE_W:0]          frame_sum;
  logic [FREE_W-1:0]        free_dec_run;
  logic [FREE_W-1:0]        free_dec_one;
  logic [FREE_W-1:0]        free_inc;

  assign tot_words = total_pages_r[TOTAL_W-1:BIT_W];
  assign num_words = (int'(tot_words) > MAX_BLOCKS) ? WCNT_W'(MAX_BLOCKS)
                                                    : WCNT_W'(tot_words);

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.page_address = out_addr_r;
  assign out_ch.free_count   = out_free_r;

  assign count_bad = (page_count_r == '0) || (page_count_r > PCNT_W'(WORD_W));
  assign scan_done = !chk_v_r && (iss_w_r >= num_words);
  assign frame_sum = {1'b0, base_frame_r} + (BASE_W + 1)'(pidx_r);

  // saturating free-page counter updates
  assign free_dec_run = (free_r > FREE_W'(run_cnt_r)) ? free_r - FREE_W'(run_cnt_r) : '0;
  assign free_dec_one = (free_r != '0) ? free_r - 1'b1 : '0;
  assign free_inc     = (free_r != FREE_MAX) ? free_r + 1'b1 : free_r;

  bpa_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(WORD_W)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpa_fit u_fit (
    .word     (ram_rdata),
    .run_cnt  (run_cnt_r),
    .run_mask (run_mask_r),
    .fit      (fit)
  );

  bpa_xlat u_xlat (
    .address    (address_r),
    .base_addr  (base_addr_r),
    .page_shift (page_shift_r),
    .num_words  (num_words),
    .loc        (xlat_loc)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r  <= SHIFT_RST;
      base_frame_r  <= BASE_RST;
      total_pages_r <= TOTAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAGE_SHIFT:  page_shift_r  <= cfg_wdata[SHIFT_W-1:0];
        CFG_BASE_FRAME:  base_frame_r  <= cfg_wdata[BASE_W-1:0];
        CFG_TOTAL_PAGES: total_pages_r <= cfg_wdata[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    base_addr_r <= PADDR_W'(base_frame_r) << page_shift_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (clr_w_r == LAST_W) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (req_type_r)
          REQ_ALLOC:   state_nxt = (free_r == '0) ? S_DONE : S_SCAN;
          REQ_CONTIG:  state_nxt = (count_bad || free_r == '0) ? S_DONE : S_SCAN;
          REQ_FREE,
          REQ_RESERVE: state_nxt = S_LOCATE;
          REQ_CLEAR:   state_nxt = S_CLEAR;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_LOCATE: state_nxt = xlat_loc.ok ? S_READ : S_DONE;
      S_READ:   state_nxt = S_MODIFY;
      S_MODIFY: state_nxt = S_DONE;
      S_SCAN: begin
        if (chk_v_r && fit.found) state_nxt = S_PADDR;
        else if (scan_done)       state_nxt = S_DONE;
      end
      S_PADDR: state_nxt = S_DONE;
      S_CLEAR: begin
        if (clr_w_r == LAST_W) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    run_cnt_nxt    = run_cnt_r;
    run_mask_nxt   = run_mask_r;
    iss_w_nxt      = iss_w_r;
    chk_w_nxt      = chk_w_r;
    chk_v_nxt      = chk_v_r;
    clr_w_nxt      = clr_w_r;
    loc_nxt        = loc_r;
    pidx_nxt       = pidx_r;
    free_nxt       = free_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_free_nxt   = out_free_r;
    ram_we    = 1'b0;
    ram_waddr = loc_r.word;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = loc_r.word;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_INIT, S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_w_r;
        clr_w_nxt = (clr_w_r == LAST_W) ? '0 : clr_w_r + 1'b1;
        if (state_r == S_CLEAR && clr_w_r == LAST_W) free_nxt = FREE_W'(total_pages_r);
      end
      S_IDLE: begin
        res_status_nxt = STS_OK;
        res_addr_nxt   = '0;
        clr_w_nxt      = '0;
        iss_w_nxt      = '0;
        chk_v_nxt      = 1'b0;
      end
      S_DECODE: begin
        run_cnt_nxt  = (req_type_r == REQ_ALLOC) ? RUN_W'(1) : page_count_r[RUN_W-1:0];
        run_mask_nxt = (run_cnt_nxt >= RUN_W'(WORD_W)) ? '1
                       : (WORD_W'(1) << run_cnt_nxt) - 1'b1;
        if (req_type_r == REQ_CONTIG && count_bad) begin
          res_status_nxt = STS_BAD_COUNT;
        end else if ((req_type_r == REQ_ALLOC || req_type_r == REQ_CONTIG) &&
                     free_r == '0) begin
          res_status_nxt = STS_NOMEM;
        end
      end
      S_LOCATE: begin
        loc_nxt = xlat_loc;
        if (!xlat_loc.ok) res_status_nxt = STS_RANGE;
      end
      S_READ: begin
        ram_re = 1'b1;
      end
      S_MODIFY: begin
        if (req_type_r == REQ_FREE) begin
          if (!ram_rdata[loc_r.bit_idx]) begin
            res_status_nxt = STS_DOUBLE_FREE;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~(WORD_W'(1) << loc_r.bit_idx);
            free_nxt  = free_inc;
          end
        end else begin
          if (ram_rdata[loc_r.bit_idx]) begin
            res_status_nxt = STS_RESERVED;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | (WORD_W'(1) << loc_r.bit_idx);
            free_nxt  = free_dec_one;
          end
        end
      end
      S_SCAN: begin
        // read issue runs one word ahead of the fit check
        if (iss_w_r < num_words) begin
          ram_re    = 1'b1;
          ram_raddr = iss_w_r[ADDR_W-1:0];
          iss_w_nxt = iss_w_r + 1'b1;
          chk_w_nxt = iss_w_r;
          chk_v_nxt = 1'b1;
        end else begin
          chk_v_nxt = 1'b0;
        end
        if (chk_v_r && fit.found) begin
          ram_we    = 1'b1;
          ram_waddr = chk_w_r[ADDR_W-1:0];
          ram_wdata = ram_rdata | (run_mask_r << fit.off);
          free_nxt  = free_dec_run;
          pidx_nxt  = {chk_w_r[ADDR_W-1:0], fit.off};
        end else if (scan_done) begin
          res_status_nxt = (req_type_r == REQ_ALLOC) ? STS_ALLOC_FAIL : STS_NOMEM;
        end
      end
      S_PADDR: begin
        res_addr_nxt = PADDR_W'(frame_sum) << page_shift_r;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_free_nxt   = free_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_w_r     <= '0;
      chk_v_r     <= 1'b0;
      iss_w_r     <= '0;
      free_r      <= FREE_W'(TOTAL_RST);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_w_r     <= clr_w_nxt;
      chk_v_r     <= chk_v_nxt;
      iss_w_r     <= iss_w_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_type_r   <= in_ch.req_type;
      address_r    <= in_ch.address;
      page_count_r <= in_ch.page_count;
    end
    run_cnt_r    <= run_cnt_nxt;
    run_mask_r   <= run_mask_nxt;
    chk_w_r      <= chk_w_nxt;
    loc_r        <= loc_nxt;
    pidx_r       <= pidx_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_free_r   <= out_free_nxt;
  end

`ifndef NO_ASSERTIONS
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re && ram_waddr == ram_raddr))
    else $error("map RAM read and write hit the same word in one cycle");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && chk_v_r) |-> (chk_w_r < num_words))
    else $error("scan checked a word beyond the usable region");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_DECODE))
    else $error("accepted request did not enter decode");
`endif

endmodule
